// File: rtl/lcd_serial_frame_formatter_top_macros.svh
// assertion macros for the lcd serial frame formatter
// used by lcd_serial_frame_formatter_top, no other dependencies
`ifndef LCD_SERIAL_FRAME_FORMATTER_TOP_MACROS_SVH
`define LCD_SERIAL_FRAME_FORMATTER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LCDSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcdsf assertion failed");

// next-cycle implication, disabled in reset
`define LCDSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcdsf assertion failed");

`endif

// File: rtl/lcdsf_pkg.sv
// shared types, codes and helpers of the lcd serial frame formatter
// no dependencies
`timescale 1ns / 1ps

package lcdsf_pkg;

	typedef enum logic [1:0] {
		OP_CMD   = 2'd0,
		OP_DATA  = 2'd1,
		OP_FRAME = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam logic [7:0] SYNC_CMD   = 8'hF8;
	localparam logic [7:0] SYNC_DATA  = 8'hFA;
	localparam logic [7:0] ADDR_BASE  = 8'h80;
	localparam logic [7:0] COL_UPPER  = 8'h88;
	localparam logic [7:0] NIBBLE_HI  = 8'hF0;

	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	localparam logic [1:0] GRP_ROW  = 2'd0;
	localparam logic [1:0] GRP_COL  = 2'd1;
	localparam logic [1:0] GRP_BYTE = 2'd2;
	localparam logic [1:0] GRP_LAST = 2'd3;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

endpackage

// File: rtl/lcd_serial_frame_formatter_top.sv
// lcd serial frame formatter, top level and only module
// depends on lcdsf_pkg and lcd_serial_frame_formatter_top_macros.svh
`timescale 1ns / 1ps

// Turns command, data and frame-word items into the serial byte stream of a
// graphic lcd controller, one byte per output item. A raw command or data item
// gives three bytes, a frame word twelve (row address, column address, then the
// two bit-reversed framebuffer bytes, each framed as sync, high nibble, low
// nibble); opcode 3 is taken and gives nothing. The output register moves one
// byte per cycle while out_stall does not hold it; the next item is taken in the
// cycle the previous item's last byte enters the output register. An accepted item
// is first held in the item registers, from which its first byte is loaded into
// the output register. The word position advances per frame word and wraps after
// ROWS rows of WORDS_PER_ROW words.
module lcd_serial_frame_formatter_top #(
	parameter int ROWS          = 64,
	parameter int WORDS_PER_ROW = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] byte_a,
	input  logic [7:0] byte_b,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] serial_byte,
	output logic       last
);

	`include "lcd_serial_frame_formatter_top_macros.svh"

	localparam int XW   = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
	localparam int YW   = $clog2(ROWS);
	localparam int HALF = ROWS / 2;

	// word position
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;

	// held item
	logic       vld_s1;
	logic [1:0] op_s1;
	logic [7:0] row_s1;
	logic [7:0] col_s1;
	logic [7:0] ra_s1;
	logic [7:0] rb_s1;
	logic [1:0] grp_q;
	logic [1:0] ph_q;

	// output register
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic          accept;
	logic          is_frame_in;
	logic          keep;
	logic          out_ok;
	logic          adv;
	logic          byte_last;
	logic          done;
	logic          is_data;
	logic          lower;
	logic [YW-1:0] y_row;
	logic [7:0]    row_cmd;
	logic [7:0]    col_cmd;
	logic [7:0]    src;
	logic [7:0]    nxt_byte;

	assign out_ok    = !out_vld_q || !out_stall;
	assign adv       = vld_s1 && out_ok;
	assign byte_last = (ph_q == lcdsf_pkg::PH_LOW) &&
		((op_s1 != lcdsf_pkg::OP_FRAME) || (grp_q == lcdsf_pkg::GRP_LAST));
	assign done      = adv && byte_last;
	assign in_stall  = vld_s1 && !done;
	assign accept    = in_valid && !in_stall;
	assign is_frame_in = (opcode == lcdsf_pkg::OP_FRAME);
	assign keep      = (opcode != lcdsf_pkg::OP_NONE);

	// address commands
	assign lower   = (y_q < YW'(HALF));
	assign y_row   = lower ? y_q : YW'(y_q - YW'(HALF));
	assign row_cmd = lcdsf_pkg::ADDR_BASE | {{(8-YW){1'b0}}, y_row};
	assign col_cmd = (lower ? lcdsf_pkg::ADDR_BASE : lcdsf_pkg::COL_UPPER) |
		{{(8-XW){1'b0}}, x_q};

	// byte select
	always_comb begin
		case (grp_q)
			lcdsf_pkg::GRP_ROW:  src = row_s1;
			lcdsf_pkg::GRP_COL:  src = col_s1;
			lcdsf_pkg::GRP_BYTE: src = ra_s1;
			default:             src = rb_s1;
		endcase
		is_data = (op_s1 == lcdsf_pkg::OP_DATA) ||
			((op_s1 == lcdsf_pkg::OP_FRAME) && grp_q[1]);
		case (ph_q)
			lcdsf_pkg::PH_SYNC: nxt_byte = is_data ? lcdsf_pkg::SYNC_DATA
				: lcdsf_pkg::SYNC_CMD;
			lcdsf_pkg::PH_HIGH: nxt_byte = src & lcdsf_pkg::NIBBLE_HI;
			default:            nxt_byte = {src[3:0], 4'h0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			vld_s1    <= 1'b0;
			op_s1     <= lcdsf_pkg::OP_CMD;
			grp_q     <= lcdsf_pkg::GRP_ROW;
			ph_q      <= lcdsf_pkg::PH_SYNC;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				if (ph_q == lcdsf_pkg::PH_LOW) begin
					ph_q  <= lcdsf_pkg::PH_SYNC;
					grp_q <= 2'(grp_q + 2'd1);
				end else begin
					ph_q <= 2'(ph_q + 2'd1);
				end
			end
			if (done) begin
				vld_s1 <= 1'b0;
			end
			if (accept) begin
				vld_s1 <= keep;
				op_s1  <= opcode;
				grp_q  <= lcdsf_pkg::GRP_ROW;
				ph_q   <= lcdsf_pkg::PH_SYNC;
				if (is_frame_in) begin
					if (x_q == XW'(WORDS_PER_ROW - 1)) begin
						x_q <= '0;
						if (y_q == YW'(ROWS - 1)) begin
							y_q <= '0;
						end else begin
							y_q <= YW'(y_q + 1'b1);
						end
					end else begin
						x_q <= XW'(x_q + 1'b1);
					end
				end
			end
			if (out_ok) begin
				out_vld_q <= adv;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_frame_in) begin
				row_s1 <= row_cmd;
				col_s1 <= col_cmd;
			end else begin
				row_s1 <= byte_a;
				col_s1 <= byte_a;
			end
			ra_s1 <= lcdsf_pkg::reverse8(byte_a);
			rb_s1 <= lcdsf_pkg::reverse8(byte_b);
		end
		if (adv) begin
			out_byte_q <= nxt_byte;
			out_last_q <= byte_last;
		end
	end

	assign out_valid   = out_vld_q;
	assign serial_byte = out_byte_q;
	assign last        = out_last_q;

	`LCDSF_ASSERT_IMP(a_x_range, clk, arst_n, 1'b1, x_q <= XW'(WORDS_PER_ROW - 1))
	`LCDSF_ASSERT_IMP(a_y_range, clk, arst_n, 1'b1, y_q <= YW'(ROWS - 1))
	`LCDSF_ASSERT_IMP(a_ph_range, clk, arst_n, vld_s1, ph_q <= lcdsf_pkg::PH_LOW)
	`LCDSF_ASSERT_IMP(a_raw_grp, clk, arst_n, vld_s1 && (op_s1 != lcdsf_pkg::OP_FRAME),
		grp_q == lcdsf_pkg::GRP_ROW)
	`LCDSF_ASSERT_NXT(a_done_free, clk, arst_n, done && !accept, !vld_s1 && out_last_q)

endmodule

// File: tb/lcd_serial_frame_formatter_top_tb.sv
// testbench for lcd_serial_frame_formatter_top: directed, random and position-run items,
// every serial byte checked against an in-bench prediction of the framing
// depends on lcdsf_pkg and lcd_serial_frame_formatter_top
`timescale 1ns / 1ps

module lcd_serial_frame_formatter_top_tb;

	localparam int ROWS          = 64;
	localparam int WORDS_PER_ROW = 8;
	localparam int IDLE_PCT      = 29;

	typedef struct packed {
		logic [7:0] serial_byte;
		logic       last;
	} serial_beat_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] opcode;
	logic [7:0] byte_a;
	logic [7:0] byte_b;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] serial_byte;
	logic       last;

	serial_beat_t expected_beats[$];
	int unsigned  word_pos;
	int           error_count;
	bit           no_idle;

	lcd_serial_frame_formatter_top #(
		.ROWS          (ROWS),
		.WORDS_PER_ROW (WORDS_PER_ROW)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.byte_a      (byte_a),
		.byte_b      (byte_b),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.serial_byte (serial_byte),
		.last        (last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic logic [7:0] bit_reverse(input logic [7:0] v);
		return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
	endfunction

	// sync byte, high nibble, low nibble moved up
	task automatic push_framed(input logic [7:0] sync, input logic [7:0] v, input logic is_last);
		expected_beats.push_back('{serial_byte: sync, last: 1'b0});
		expected_beats.push_back('{serial_byte: v & lcdsf_pkg::NIBBLE_HI, last: 1'b0});
		expected_beats.push_back('{serial_byte: (v << 4) & lcdsf_pkg::NIBBLE_HI,
			last: is_last});
	endtask

	task automatic predict_serial_bytes(input lcdsf_pkg::opcode_t op, input logic [7:0] a,
			input logic [7:0] b);
		int unsigned row_y;
		int unsigned col_x;
		int unsigned half;
		logic [7:0]  row_cmd;
		logic [7:0]  col_cmd;
		half = ROWS / 2;
		case (op)
			lcdsf_pkg::OP_CMD: begin
				push_framed(lcdsf_pkg::SYNC_CMD, a, 1'b1);
			end
			lcdsf_pkg::OP_DATA: begin
				push_framed(lcdsf_pkg::SYNC_DATA, a, 1'b1);
			end
			lcdsf_pkg::OP_FRAME: begin
				if (word_pos >= ROWS * WORDS_PER_ROW) begin
					word_pos = 0;
				end
				row_y = word_pos / WORDS_PER_ROW;
				col_x = word_pos % WORDS_PER_ROW;
				if (row_y < half) begin
					row_cmd = lcdsf_pkg::ADDR_BASE | 8'(row_y);
					col_cmd = lcdsf_pkg::ADDR_BASE | 8'(col_x);
				end else begin
					row_cmd = lcdsf_pkg::ADDR_BASE | 8'(row_y - half);
					col_cmd = lcdsf_pkg::COL_UPPER | 8'(col_x);
				end
				push_framed(lcdsf_pkg::SYNC_CMD, row_cmd, 1'b0);
				push_framed(lcdsf_pkg::SYNC_CMD, col_cmd, 1'b0);
				push_framed(lcdsf_pkg::SYNC_DATA, bit_reverse(a), 1'b0);
				push_framed(lcdsf_pkg::SYNC_DATA, bit_reverse(b), 1'b1);
				word_pos++;
				if (word_pos >= ROWS * WORDS_PER_ROW) begin
					word_pos = 0;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input lcdsf_pkg::opcode_t op, input logic [7:0] a,
			input logic [7:0] b);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		byte_a <= a;
		byte_b <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_serial_bytes(op, a, b);
	endtask

	task automatic send_random_item(input int frame_pct);
		int                 pick;
		lcdsf_pkg::opcode_t op;
		pick = $urandom_range(99);
		if (pick < frame_pct) begin
			op = lcdsf_pkg::OP_FRAME;
		end else if (pick < frame_pct + (100 - frame_pct) * 4 / 9) begin
			op = lcdsf_pkg::OP_CMD;
		end else if (pick < frame_pct + (100 - frame_pct) * 8 / 9) begin
			op = lcdsf_pkg::OP_DATA;
		end else begin
			op = lcdsf_pkg::OP_NONE;
		end
		send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic test_directed_items;
		send_item(lcdsf_pkg::OP_CMD, 8'h00, 8'hFF);
		send_item(lcdsf_pkg::OP_CMD, 8'hFF, 8'h00);
		send_item(lcdsf_pkg::OP_DATA, 8'h00, 8'h00);
		send_item(lcdsf_pkg::OP_DATA, 8'hFF, 8'hFF);
		send_item(lcdsf_pkg::OP_DATA, 8'h5A, 8'hA5);
		send_item(lcdsf_pkg::OP_CMD, 8'hA5, 8'h5A);
		send_item(lcdsf_pkg::OP_NONE, 8'hFF, 8'hFF);
		send_item(lcdsf_pkg::OP_FRAME, 8'h00, 8'hFF);
		send_item(lcdsf_pkg::OP_FRAME, 8'hFF, 8'h00);
		send_item(lcdsf_pkg::OP_NONE, 8'h00, 8'h00);
		send_item(lcdsf_pkg::OP_FRAME, 8'h01, 8'h80);
		send_item(lcdsf_pkg::OP_FRAME, 8'hA5, 8'h3C);
		send_item(lcdsf_pkg::OP_CMD, 8'h12, 8'h34);
		send_item(lcdsf_pkg::OP_FRAME, 8'hF0, 8'h0F);
		send_item(lcdsf_pkg::OP_DATA, 8'h81, 8'h7E);
	endtask

	task automatic test_random_items;
		for (int i = 0; i < 150; i++) begin
			no_idle = (i >= 60 && i < 110);
			send_random_item(60);
		end
		no_idle = 1'b0;
	endtask

	// a run of frame words over several rows, with a few raw items mixed in
	task automatic test_position_wrap;
		int remaining;
		remaining = 64;
		while (remaining > 0) begin
			no_idle = (remaining < 24);
			if ($urandom_range(7) == 0) begin
				send_random_item(0);
			end else begin
				send_item(lcdsf_pkg::OP_FRAME, 8'($urandom_range(255)),
					8'($urandom_range(255)));
				remaining--;
			end
		end
		no_idle = 1'b0;
	endtask

	always @(negedge clk) begin
		out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		serial_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected serial byte %02h last %0b",
					serial_byte, last));
			end else begin
				want = expected_beats.pop_front();
				if (serial_byte !== want.serial_byte) begin
					report_mismatch($sformatf("serial_byte %02h, expected %02h",
						serial_byte, want.serial_byte));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
						last, want.last, want.serial_byte));
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = lcdsf_pkg::OP_CMD;
		byte_a = 8'h00;
		byte_b = 8'h00;
		no_idle = 1'b0;
		error_count = 0;
		word_pos = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_items();
		test_random_items();
		test_position_wrap();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
